FILE: rtl/rip_v2_packet_parser_unit_macros.svh
// Assertion macros shared by the parser RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RIP_V2_PACKET_PARSER_UNIT_MACROS_SVH
`define RIP_V2_PACKET_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside of reset.
`define RPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside of reset.
`define RPP_ASSERT_NEVER(lbl, cond, msg) \
    `RPP_ASSERT(lbl, (!(cond)), msg)

`else

`define RPP_ASSERT(lbl, prop, msg)
`define RPP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/rpp_pkg.sv
`timescale 1ns / 1ps

package rpp_pkg;

    // One result word: either a parsed route entry or the final packet status.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  command;
        logic [4:0]  entry_index;
        logic [31:0] address;
        logic [31:0] mask;
        logic [31:0] hop_addr;
        logic [4:0]  metric;
        logic [2:0]  status;
        logic [4:0]  entry_count;
        logic        last_result;
    } result_t;

    // Result kinds.
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Packet status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_LENGTH     = 3'd1;
    localparam logic [2:0] ST_NOT_UDP    = 3'd2;
    localparam logic [2:0] ST_UDP_LENGTH = 3'd3;
    localparam logic [2:0] ST_RIP_HEADER = 3'd4;
    localparam logic [2:0] ST_METRIC     = 3'd5;
    localparam logic [2:0] ST_MASK       = 3'd6;
    localparam logic [2:0] ST_FAMILY_TAG = 3'd7;

    // Protocol constants.
    localparam logic [7:0]  PROTO_UDP     = 8'h11;
    localparam logic [15:0] MIN_TOTAL_LEN = 16'd32;
    localparam logic [7:0]  CMD_REQUEST   = 8'd1;
    localparam logic [7:0]  CMD_RESPONSE  = 8'd2;
    localparam logic [7:0]  RIP_VERSION   = 8'd2;
    localparam logic [15:0] FAMILY_INET   = 16'd2;
    localparam logic [31:0] METRIC_MAX    = 32'd16;
    localparam int          RIP_HDR_BYTES = 12;
    localparam int          ENTRY_BYTES   = 20;
    localparam logic [4:0]  ENTRY_LAST    = 5'd19;

    // Result queue.
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);

endpackage

FILE: rtl/rpp_if.sv
`timescale 1ns / 1ps

// Packet byte channel.
interface rpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel.
interface rpp_result_if;
    logic             valid;
    logic             ready;
    rpp_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rip_v2_packet_parser_unit.sv
`timescale 1ns / 1ps
// RIPv2-over-UDP/IPv4 packet parser.
// pkt_bytes carries one IPv4 packet byte per word in wire order; last_byte
// marks the final byte of a packet. results carries one word per parsed route
// entry and one final status word per packet (last_result set).
// A byte is taken in every cycle while the result queue has two free slots,
// so the sustained rate is one byte per cycle. The per-byte header checks
// and entry assembly are done between the parser state registers and a
// four-word result queue; a result is registered into the queue as the byte
// that completes it is taken. A byte that completes an entry and is also the
// last byte gives two words, written together with the entry ahead.
// The entry count is derived from the UDP length through a registered
// reciprocal multiply; it is first used at least seven bytes later.
// When the receiver stalls, results collect in the queue and pkt_bytes.ready
// drops once fewer than two slots are free; nothing is lost.
// Reset clears all parser state and empties the queue; the parser also
// returns to its reset state after every last byte.
`include "rip_v2_packet_parser_unit_macros.svh"

module rip_v2_packet_parser_unit #(
    parameter int MAX_ENTRIES = 25
) (
    input  logic         clk,
    input  logic         rst_n,
    rpp_byte_if.sink     pkt_bytes,
    rpp_result_if.source results
);

    // Entry count above the limit exactly when the UDP length reaches this.
    localparam int UDP_LIMIT = rpp_pkg::ENTRY_BYTES * (MAX_ENTRIES + 1)
                               + rpp_pkg::RIP_HDR_BYTES;

    // Parser state.
    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [5:0]  hl_reg, hl_next;
    logic [15:0] udp_reg, udp_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [4:0]  ebyte_reg, ebyte_next;
    logic [4:0]  seen_reg, seen_next;
    logic [31:0] ft_reg, ft_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] hop_reg, hop_next;
    logic [31:0] metric_reg, metric_next;
    logic [2:0]  err_reg, err_next;
    logic        udp_seen_reg, udp_seen_next;
    logic        rip_seen_reg, rip_seen_next;
    logic [11:0] etotal_reg, etotal_next;

    // Result queue.
    rpp_pkg::result_t                  fifo_mem [rpp_pkg::RESULT_DEPTH];
    logic [rpp_pkg::RESULT_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [rpp_pkg::RESULT_PTR_W:0]    count_reg;

    logic             acc;
    logic             last;
    logic [7:0]       b;
    logic [5:0]       hl_cur;
    logic [15:0]      hl16;
    logic             in_window;
    logic [15:0]      udp_new;
    logic [31:0]      metric_new;
    logic [31:0]      inv;
    logic             fam_ok;
    logic [16:0]      received;
    logic [2:0]       st;
    logic             entry_push;
    logic             status_push;
    logic [1:0]       push_count;
    logic             pop;
    rpp_pkg::result_t entry_res;
    rpp_pkg::result_t status_res;
    rpp_pkg::result_t slot0;
    rpp_pkg::result_t slot1;

    // Keep the smallest nonzero error code.
    function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] code);
        logic [2:0] r;
        r = cur;
        if (cur == rpp_pkg::ST_OK || code < cur)
        begin
            r = code;
        end
        return r;
    endfunction

    // Handshakes.
    assign acc  = pkt_bytes.valid && pkt_bytes.ready;
    assign pop  = results.valid && results.ready;
    assign b    = pkt_bytes.data_byte;
    assign last = pkt_bytes.last_byte;

    assign pkt_bytes.ready = (count_reg <= (rpp_pkg::RESULT_PTR_W + 1)'(rpp_pkg::RESULT_DEPTH - 2));
    assign results.valid   = (count_reg != '0);
    assign results.data    = fifo_mem[rd_ptr_reg];

    // Header length applies on the byte that carries it.
    assign hl_cur    = (pos_reg == 16'd0) ? {b[3:0], 2'b00} : hl_reg;
    assign hl16      = {10'd0, hl_cur};
    assign in_window = (pos_reg < 16'd4) || (pos_reg < total_reg);

    // Per-byte parsing.
    always_comb
    begin
        pos_next      = pos_reg;
        total_next    = total_reg;
        hl_next       = hl_reg;
        udp_next      = udp_reg;
        cmd_next      = cmd_reg;
        ebyte_next    = ebyte_reg;
        seen_next     = seen_reg;
        ft_next       = ft_reg;
        addr_next     = addr_reg;
        mask_next     = mask_reg;
        hop_next      = hop_reg;
        metric_next   = metric_reg;
        err_next      = err_reg;
        udp_seen_next = udp_seen_reg;
        rip_seen_next = rip_seen_reg;
        entry_push    = 1'b0;
        status_push   = 1'b0;
        st            = rpp_pkg::ST_OK;
        udp_new       = {udp_reg[15:8], b};
        metric_new    = {metric_reg[23:0], b};
        inv           = ~mask_reg;
        fam_ok        = (cmd_reg == rpp_pkg::CMD_REQUEST && ft_reg[31:16] == 16'd0) ||
                        (cmd_reg == rpp_pkg::CMD_RESPONSE &&
                         ft_reg[31:16] == rpp_pkg::FAMILY_INET);
        received      = {1'b0, pos_reg} + 17'd1;
        entry_res     = '0;
        status_res    = '0;

        if (acc)
        begin
            if (in_window)
            begin
                // IP header fields.
                if (pos_reg == 16'd0)
                begin
                    hl_next = hl_cur;
                end
                if (pos_reg == 16'd2)
                begin
                    total_next = {b, 8'h00};
                end
                if (pos_reg == 16'd3)
                begin
                    total_next = {total_reg[15:8], b};
                    if ({total_reg[15:8], b} < rpp_pkg::MIN_TOTAL_LEN)
                    begin
                        err_next = merge_err(err_next, rpp_pkg::ST_LENGTH);
                    end
                end
                if (pos_reg == 16'd9 && b != rpp_pkg::PROTO_UDP)
                begin
                    err_next = merge_err(err_next, rpp_pkg::ST_NOT_UDP);
                end

                // UDP length.
                if (pos_reg == hl16 + 16'd4)
                begin
                    udp_next = {b, 8'h00};
                end
                if (pos_reg == hl16 + 16'd5)
                begin
                    udp_next      = udp_new;
                    udp_seen_next = 1'b1;
                    if (({1'b0, udp_new} + {11'd0, hl_cur}) != {1'b0, total_reg})
                    begin
                        err_next = merge_err(err_next, rpp_pkg::ST_UDP_LENGTH);
                    end
                    else if ({1'b0, udp_new} >= 17'(UDP_LIMIT))
                    begin
                        err_next = merge_err(err_next, rpp_pkg::ST_RIP_HEADER);
                    end
                end

                // RIP header.
                if (pos_reg == hl16 + 16'd8)
                begin
                    cmd_next = b;
                    if (b != rpp_pkg::CMD_REQUEST && b != rpp_pkg::CMD_RESPONSE)
                    begin
                        err_next = merge_err(err_next, rpp_pkg::ST_RIP_HEADER);
                    end
                end
                if (pos_reg == hl16 + 16'd9 && b != rpp_pkg::RIP_VERSION)
                begin
                    err_next = merge_err(err_next, rpp_pkg::ST_RIP_HEADER);
                end
                if ((pos_reg == hl16 + 16'd10 || pos_reg == hl16 + 16'd11) && b != 8'd0)
                begin
                    err_next = merge_err(err_next, rpp_pkg::ST_RIP_HEADER);
                end
                if (pos_reg == hl16 + 16'd11)
                begin
                    rip_seen_next = 1'b1;
                end

                // Route entry assembly and checks.
                if (err_next == rpp_pkg::ST_OK && udp_seen_reg && rip_seen_reg &&
                    pos_reg >= hl16 + 16'd12 && {7'd0, seen_reg} < etotal_reg)
                begin
                    if (ebyte_reg < 5'd4)
                    begin
                        ft_next = {ft_reg[23:0], b};
                    end
                    else if (ebyte_reg < 5'd8)
                    begin
                        addr_next = {addr_reg[23:0], b};
                    end
                    else if (ebyte_reg < 5'd12)
                    begin
                        mask_next = {mask_reg[23:0], b};
                    end
                    else if (ebyte_reg < 5'd16)
                    begin
                        hop_next = {hop_reg[23:0], b};
                    end
                    else
                    begin
                        metric_next = metric_new;
                    end

                    if (ebyte_reg >= rpp_pkg::ENTRY_LAST)
                    begin
                        ebyte_next = 5'd0;
                        if (metric_new == 32'd0 || metric_new > rpp_pkg::METRIC_MAX)
                        begin
                            err_next = merge_err(err_next, rpp_pkg::ST_METRIC);
                        end
                        else if ((inv & (inv + 32'd1)) != 32'd0)
                        begin
                            err_next = merge_err(err_next, rpp_pkg::ST_MASK);
                        end
                        else if (!fam_ok || ft_reg[15:0] != 16'd0)
                        begin
                            err_next = merge_err(err_next, rpp_pkg::ST_FAMILY_TAG);
                        end
                        else
                        begin
                            entry_push            = 1'b1;
                            entry_res.result_kind = rpp_pkg::KIND_ENTRY;
                            entry_res.command     = cmd_next;
                            entry_res.entry_index = seen_reg;
                            entry_res.address     = addr_reg;
                            entry_res.mask        = mask_reg;
                            entry_res.hop_addr    = hop_reg;
                            entry_res.metric      = metric_new[4:0];
                            seen_next             = seen_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        ebyte_next = ebyte_reg + 5'd1;
                    end
                end
            end

            // Byte count saturates.
            if (pos_reg != 16'hFFFF)
            begin
                pos_next = pos_reg + 16'd1;
            end

            // Final status, length error ranked first.
            if (last)
            begin
                if (total_next < rpp_pkg::MIN_TOTAL_LEN || {1'b0, total_next} > received)
                begin
                    st = rpp_pkg::ST_LENGTH;
                end
                else if (err_next != rpp_pkg::ST_OK)
                begin
                    st = err_next;
                end
                else if (!udp_seen_next)
                begin
                    st = rpp_pkg::ST_UDP_LENGTH;
                end
                else if (!rip_seen_next)
                begin
                    st = rpp_pkg::ST_RIP_HEADER;
                end
                else
                begin
                    st = rpp_pkg::ST_OK;
                end
                status_push            = 1'b1;
                status_res.result_kind = rpp_pkg::KIND_STATUS;
                status_res.command     = cmd_next;
                status_res.status      = st;
                status_res.entry_count = seen_next;
                status_res.last_result = 1'b1;

                pos_next      = '0;
                total_next    = '0;
                hl_next       = '0;
                udp_next      = '0;
                cmd_next      = '0;
                ebyte_next    = '0;
                seen_next     = '0;
                ft_next       = '0;
                addr_next     = '0;
                mask_next     = '0;
                hop_next      = '0;
                metric_next   = '0;
                err_next      = rpp_pkg::ST_OK;
                udp_seen_next = 1'b0;
                rip_seen_next = 1'b0;
            end
        end
    end

    // Entry count: (udp_length - 12) / 20, as a quarter divided by five
    // through a reciprocal multiply, exact for every 14-bit quotient input.
    logic [15:0] udp_body;
    logic [30:0] etotal_prod;

    assign udp_body    = (udp_reg < 16'(rpp_pkg::RIP_HDR_BYTES)) ? 16'd0 :
                         (udp_reg - 16'(rpp_pkg::RIP_HDR_BYTES));
    assign etotal_prod = {3'd0, udp_body[15:2]} * 31'd52429;
    assign etotal_next = etotal_prod[29:18];

    // Queue slot order: an entry goes ahead of the status of the same byte.
    assign push_count = {1'b0, entry_push} + {1'b0, status_push};
    assign slot0      = entry_push ? entry_res : status_res;
    assign slot1      = status_res;

    // Parser and queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            total_reg    <= '0;
            hl_reg       <= '0;
            udp_reg      <= '0;
            cmd_reg      <= '0;
            ebyte_reg    <= '0;
            seen_reg     <= '0;
            ft_reg       <= '0;
            addr_reg     <= '0;
            mask_reg     <= '0;
            hop_reg      <= '0;
            metric_reg   <= '0;
            err_reg      <= rpp_pkg::ST_OK;
            udp_seen_reg <= 1'b0;
            rip_seen_reg <= 1'b0;
            etotal_reg   <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            hl_reg       <= hl_next;
            udp_reg      <= udp_next;
            cmd_reg      <= cmd_next;
            ebyte_reg    <= ebyte_next;
            seen_reg     <= seen_next;
            ft_reg       <= ft_next;
            addr_reg     <= addr_next;
            mask_reg     <= mask_next;
            hop_reg      <= hop_next;
            metric_reg   <= metric_next;
            err_reg      <= err_next;
            udp_seen_reg <= udp_seen_next;
            rip_seen_reg <= rip_seen_next;
            etotal_reg   <= etotal_next;
            wr_ptr_reg   <= wr_ptr_reg + rpp_pkg::RESULT_PTR_W'(push_count);
            rd_ptr_reg   <= rd_ptr_reg + rpp_pkg::RESULT_PTR_W'(pop);
            count_reg    <= count_reg + (rpp_pkg::RESULT_PTR_W + 1)'(push_count)
                            - (rpp_pkg::RESULT_PTR_W + 1)'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push_count == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + rpp_pkg::RESULT_PTR_W'(1)] <= slot1;
        end
    end

    // Checks.
    `RPP_ASSERT_NEVER(a_queue_bound,
        (count_reg > (rpp_pkg::RESULT_PTR_W + 1)'(rpp_pkg::RESULT_DEPTH)),
        "result queue overflow")
    `RPP_ASSERT(a_last_clears,
        ((acc && last) |=> (pos_reg == 16'd0 && err_reg == rpp_pkg::ST_OK && !udp_seen_reg)),
        "parser state not cleared after last byte")
    `RPP_ASSERT(a_entry_counts,
        ((entry_push && !last) |=> (seen_reg == $past(seen_reg) + 5'd1)),
        "entry count did not advance")
    `RPP_ASSERT_NEVER(a_seen_bound,
        (seen_reg > 5'(MAX_ENTRIES)),
        "more entries than the limit")

endmodule
